FILE: rtl/point_in_polygon_crossing_macros.svh
// Assertion macros shared by the point-in-polygon RTL.
`ifndef POINT_IN_POLYGON_CROSSING_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define PIPC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define PIPC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pipc_pkg.sv
// Shared types and codes for the point-in-polygon crossing test.
package pipc_pkg;

  localparam int OP_BITS = 2;

  // work queued from the front end to the back end
  typedef enum logic [OP_BITS-1:0] {
    OP_START = 2'd0,
    OP_EDGE  = 2'd1,
    OP_CLOSE = 2'd2
  } job_op_t;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_VERTEX = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_MUL  = 2'd1,
    BK_DIV  = 2'd2,
    BK_FIN  = 2'd3
  } back_state_t;

endpackage

FILE: rtl/pipc_fifo.sv
// Small register FIFO between the front and back ends.
`include "point_in_polygon_crossing_macros.svh"

module pipc_fifo #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `PIPC_CHECK(a_count_bound, 1'b1, count <= CNTW'(DEPTH), "fifo count beyond depth")

endmodule

FILE: rtl/pipc_front.sv
// Front end: takes items, tracks first/previous vertex, queues edge jobs.
module pipc_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      push,
  output logic                                      full,
  input  logic                                      kind,
  input  logic signed [COORD_BITS-1:0]              coord_x,
  input  logic signed [COORD_BITS-1:0]              coord_y,
  input  logic                                      final_vertex,
  output logic                                      q_push,
  output logic [pipc_pkg::OP_BITS+4*COORD_BITS-1:0] q_data,
  input  logic                                      q_full
);

  typedef struct packed {
    pipc_pkg::job_op_t            op;
    logic signed [COORD_BITS-1:0] xi;
    logic signed [COORD_BITS-1:0] yi;
    logic signed [COORD_BITS-1:0] xj;
    logic signed [COORD_BITS-1:0] yj;
  } job_t;

  logic signed [COORD_BITS-1:0] first_vx;
  logic signed [COORD_BITS-1:0] first_vy;
  logic signed [COORD_BITS-1:0] prev_vx;
  logic signed [COORD_BITS-1:0] prev_vy;
  logic                         seen_first;
  logic                         pend_valid;
  job_t                         pend_job;
  job_t                         job_a;
  logic                         need_a;
  logic                         need_b;
  logic                         acc;
  logic                         is_vertex;

  assign full      = pend_valid || q_full;
  assign acc       = push && !full;
  assign is_vertex = (kind == pipc_pkg::KIND_VERTEX);

  always_comb begin
    job_a.op = pipc_pkg::OP_START;
    job_a.xi = coord_x;
    job_a.yi = coord_y;
    job_a.xj = coord_x;
    job_a.yj = coord_y;
    need_a   = 1'b1;
    if (is_vertex) begin
      if (!seen_first) begin
        // lone first vertex only yields the degenerate closing edge
        job_a.op = pipc_pkg::OP_CLOSE;
        need_a   = final_vertex;
      end else begin
        job_a.op = pipc_pkg::OP_EDGE;
        job_a.xj = prev_vx;
        job_a.yj = prev_vy;
      end
    end
  end

  assign need_b = is_vertex && seen_first && final_vertex;
  assign q_push = (acc && need_a) || (pend_valid && !q_full);
  assign q_data = pend_valid ? pend_job : job_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_first <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (acc) begin
        seen_first <= is_vertex && !final_vertex;
      end
      if (acc && need_b) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_vertex) begin
      prev_vx <= coord_x;
      prev_vy <= coord_y;
      if (!seen_first) begin
        first_vx <= coord_x;
        first_vy <= coord_y;
      end
    end
    if (acc && need_b) begin
      // closing edge: i is the first vertex, j the last
      pend_job.op <= pipc_pkg::OP_CLOSE;
      pend_job.xi <= first_vx;
      pend_job.yi <= first_vy;
      pend_job.xj <= coord_x;
      pend_job.yj <= coord_y;
    end
  end

endmodule

FILE: rtl/pipc_back.sv
// Back end: straddle test, product, serial divide, parity and result register.
`include "point_in_polygon_crossing_macros.svh"

module pipc_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [pipc_pkg::OP_BITS+4*COORD_BITS-1:0] head,
  input  logic                                      head_valid,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  logic                                      pop,
  output logic                                      inside_res
);

  localparam int W    = COORD_BITS + 1;
  localparam int NUMW = 2 * W;
  localparam int CNTW = $clog2(NUMW);
  localparam int SUMW = W + 2;

  typedef struct packed {
    pipc_pkg::job_op_t            op;
    logic signed [COORD_BITS-1:0] xi;
    logic signed [COORD_BITS-1:0] yi;
    logic signed [COORD_BITS-1:0] xj;
    logic signed [COORD_BITS-1:0] yj;
  } job_t;

  pipc_pkg::back_state_t state;
  pipc_pkg::back_state_t state_next;

  job_t                         head_job;
  logic signed [COORD_BITS-1:0] qx;
  logic signed [COORD_BITS-1:0] qy;
  logic                         parity;
  pipc_pkg::job_op_t            op_r;
  logic signed [COORD_BITS-1:0] xi_r;
  logic [W-1:0]                 mag_dx;
  logic [W-1:0]                 mag_dy;
  logic [W-1:0]                 mag_den;
  logic                         neg;
  logic                         straddle;
  logic [NUMW-1:0]              num;
  logic [W-1:0]                 rem;
  logic [CNTW-1:0]              cnt;

  logic signed [W-1:0]    dx_c;
  logic signed [W-1:0]    dy_c;
  logic signed [W-1:0]    den_c;
  logic                   strad_c;
  logic                   is_start;
  logic [W:0]             shifted;
  logic                   ge;
  logic signed [W:0]      q_s;
  logic signed [SUMW-1:0] lim;
  logic                   cross_c;
  logic                   parity_new;
  logic                   out_free;
  logic                   fin_done;
  logic                   load_out;

  assign head_job = head;
  assign is_start = (head_job.op == pipc_pkg::OP_START);

  // edge setup straight off the queue head
  assign dx_c  = W'(head_job.xj) - W'(head_job.xi);
  assign dy_c  = W'(qy) - W'(head_job.yi);
  assign den_c = W'(head_job.yj) - W'(head_job.yi);
  assign strad_c = ((head_job.yi <= qy) && (qy < head_job.yj)) ||
                   ((head_job.yj <= qy) && (qy < head_job.yi));

  // one restoring step per cycle
  assign shifted = {rem, num[NUMW-1]};
  assign ge      = (shifted >= {1'b0, mag_den});

  assign q_s = neg ? -$signed({1'b0, num[W-1:0]}) : $signed({1'b0, num[W-1:0]});
  assign lim = SUMW'(q_s) + SUMW'(xi_r);
  assign cross_c    = straddle && (SUMW'(qx) < lim);
  assign parity_new = parity ^ cross_c;

  always_comb begin
    state_next = state;
    case (state)
      pipc_pkg::BK_IDLE: begin
        if (head_valid && !is_start) begin
          state_next = strad_c ? pipc_pkg::BK_MUL : pipc_pkg::BK_FIN;
        end
      end
      pipc_pkg::BK_MUL: state_next = pipc_pkg::BK_DIV;
      pipc_pkg::BK_DIV: begin
        if (cnt == CNTW'(NUMW - 1)) begin
          state_next = pipc_pkg::BK_FIN;
        end
      end
      pipc_pkg::BK_FIN: begin
        if (fin_done) begin
          state_next = pipc_pkg::BK_IDLE;
        end
      end
      default: state_next = pipc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    out_free = !out_valid || pop;
    q_pop    = (state == pipc_pkg::BK_IDLE) && head_valid;
    fin_done = (state == pipc_pkg::BK_FIN) &&
               ((op_r != pipc_pkg::OP_CLOSE) || out_free);
    load_out = fin_done && (op_r == pipc_pkg::OP_CLOSE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pipc_pkg::BK_IDLE;
      qx        <= '0;
      qy        <= '0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && is_start) begin
        qx     <= head_job.xi;
        qy     <= head_job.yi;
        parity <= 1'b0;
      end else if (fin_done) begin
        parity <= load_out ? 1'b0 : parity_new;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r     <= head_job.op;
      xi_r     <= head_job.xi;
      straddle <= strad_c;
      mag_dx   <= dx_c[W-1] ? W'(-dx_c) : W'(dx_c);
      mag_dy   <= dy_c[W-1] ? W'(-dy_c) : W'(dy_c);
      mag_den  <= den_c[W-1] ? W'(-den_c) : W'(den_c);
      neg      <= dx_c[W-1] ^ dy_c[W-1] ^ den_c[W-1];
    end
    if (state == pipc_pkg::BK_MUL) begin
      num <= NUMW'(mag_dx) * NUMW'(mag_dy);
      rem <= '0;
      cnt <= '0;
    end else if (state == pipc_pkg::BK_DIV) begin
      num <= {num[NUMW-2:0], ge};
      rem <= ge ? W'(shifted - {1'b0, mag_den}) : shifted[W-1:0];
      cnt <= cnt + 1'b1;
    end
    if (load_out) begin
      inside_res <= parity_new;
    end
  end

  `PIPC_CHECK_NEXT(a_start_clears, q_pop && is_start, !parity, "parity not cleared by start")
  `PIPC_CHECK_NEXT(a_result_clears, load_out, !parity && out_valid, "result did not reset parity")

endmodule

FILE: rtl/point_in_polygon_crossing.sv
// Even-odd point-in-polygon test: a start item sets the query point, vertex items
// follow, and the final vertex closes the polygon and yields one inside/outside
// result. Each vertex past the first is one edge job (the final one adds the
// closing edge); jobs go through a short queue to the back end, which handles one
// edge at a time. An edge that straddles the query y goes through a product step and
// then the serial restoring divider at one quotient bit per cycle; an edge that does
// not straddle skips both, and a start item only loads the query point. The
// front end takes a new item per cycle while the queue has room, except that
// full stays high after a final vertex of a polygon with two or more vertices
// until its closing edge is queued.
`include "point_in_polygon_crossing_macros.svh"

module point_in_polygon_crossing #(
  parameter int COORD_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic                         final_vertex,
  output logic                         empty,
  input  logic                         pop,
  output logic                         inside_res
);

  localparam int JOB_W = pipc_pkg::OP_BITS + 4 * COORD_BITS;

  logic             fifo_push;
  logic [JOB_W-1:0] fifo_data;
  logic             fifo_full;
  logic             fifo_pop;
  logic [JOB_W-1:0] fifo_head;
  logic             fifo_empty;
  logic             out_valid;

  pipc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .final_vertex(final_vertex),
    .q_push      (fifo_push),
    .q_data      (fifo_data),
    .q_full      (fifo_full)
  );

  pipc_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (fifo_push),
    .push_data(fifo_data),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .head     (fifo_head),
    .empty    (fifo_empty)
  );

  pipc_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (fifo_head),
    .head_valid(!fifo_empty),
    .q_pop     (fifo_pop),
    .out_valid (out_valid),
    .pop       (pop),
    .inside_res(inside_res)
  );

  assign empty = !out_valid;

  `PIPC_CHECK(a_no_overflow, fifo_push, !fifo_full, "edge job pushed into full queue")

endmodule
